@@ hw/rtl/ocl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocl_pkg: shared definitions for the outcode line clipper
// Field widths, outcode bit positions, default parameters and the outcode
// function used by the clipping sequencer.
// ----------------------------------------------------------------------------
package ocl_pkg;

	localparam int COORD_W = 32;            // input coordinate width
	localparam int OUT_W   = 18;            // clipped coordinate width
	localparam int MAG_W   = COORD_W + 1;   // magnitude of a coordinate difference
	localparam int PROD_W  = 2 * MAG_W;     // product and dividend width

	localparam int PASS_LIMIT_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// outcode bit positions
	localparam int CODE_LEFT   = 0;
	localparam int CODE_RIGHT  = 1;
	localparam int CODE_BOTTOM = 2;
	localparam int CODE_TOP    = 3;

	typedef logic [3:0] outcode_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	function automatic outcode_t outcode(input coord_t x, input coord_t y, input coord_t one);
		outcode_t c;
		c = '0;
		if (x < -one)
			c[CODE_LEFT] = 1'b1;
		else if (x > one)
			c[CODE_RIGHT] = 1'b1;
		if (y < -one)
			c[CODE_BOTTOM] = 1'b1;
		else if (y > one)
			c[CODE_TOP] = 1'b1;
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/outcode_line_clip_unit_square.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// outcode_line_clip_unit_square: Cohen-Sutherland clipper against [-1, +1]^2
// Clips one segment in signed fixed point with a shared add/subtract unit
// that performs a shift-add multiply and a restoring divide for each pass.
// ----------------------------------------------------------------------------
// Issue a transaction by raising start while busy is low; the unit stays
// busy through the clip passes the segment completes (at most PASS_LIMIT,
// four or fewer for any real segment) and the outcode test that ends it, or
// the test and setup of a pass that drops the segment for a zero span.
// Each pass runs the outcode test, the setup, the bit-serial multiply, the
// bit-serial divide and the endpoint update, in that order; the multiply,
// divide and update share one 67-bit adder. The result appears in the first
// cycle that busy is low, valid for exactly one cycle while done is high; it
// must be captured then, as the unit does not wait. A new transaction may be
// issued in that same cycle. A rejected segment reports accepted low and all
// clipped coordinates zero.
// ----------------------------------------------------------------------------
module outcode_line_clip_unit_square #(
	parameter int PASS_LIMIT = ocl_pkg::PASS_LIMIT_DEF,
	parameter int FRAC_BITS  = ocl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [ocl_pkg::COORD_W-1:0]  start_x,
	input  wire logic signed [ocl_pkg::COORD_W-1:0]  start_y,
	input  wire logic signed [ocl_pkg::COORD_W-1:0]  end_x,
	input  wire logic signed [ocl_pkg::COORD_W-1:0]  end_y,
	output logic                                     done,
	output logic                                     accepted,
	output logic signed [ocl_pkg::OUT_W-1:0]         clip_start_x,
	output logic signed [ocl_pkg::OUT_W-1:0]         clip_start_y,
	output logic signed [ocl_pkg::OUT_W-1:0]         clip_end_x,
	output logic signed [ocl_pkg::OUT_W-1:0]         clip_end_y
);

	localparam int CW     = ocl_pkg::COORD_W;
	localparam int OW     = ocl_pkg::OUT_W;
	localparam int MW     = ocl_pkg::MAG_W;
	localparam int PW     = ocl_pkg::PROD_W;
	localparam int AW     = PW + 1;
	localparam int CNT_W  = $clog2(MW);
	localparam int PASS_W = $clog2(PASS_LIMIT + 1);

	localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_UPD
	} state_t;

	state_t                 state_q;
	logic signed [CW-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic [PASS_W-1:0]      pass_q;
	logic                   sel_y_q;
	logic                   mv1_q;
	logic signed [CW-1:0]   edge_q;
	logic                   neg_q;
	logic [PW-1:0]          ma_q;
	logic [MW-1:0]          mb_q;
	logic [MW-1:0]          dvs_q;
	logic [PW-1:0]          acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic                   accepted_q;
	logic signed [OW-1:0]   csx_q, csy_q, cex_q, cey_q;

	// outcode test
	ocl_pkg::outcode_t c0, c1, csel;
	logic              sel_y_d;
	logic signed [CW-1:0] edge_d;

	always_comb begin
		c0   = ocl_pkg::outcode(x0_q, y0_q, ONE);
		c1   = ocl_pkg::outcode(x1_q, y1_q, ONE);
		csel = (c0 != '0) ? c0 : c1;
		if (csel[ocl_pkg::CODE_TOP] || csel[ocl_pkg::CODE_BOTTOM]) begin
			sel_y_d = 1'b1;
			edge_d  = csel[ocl_pkg::CODE_TOP] ? ONE : -ONE;
		end else begin
			sel_y_d = 1'b0;
			edge_d  = csel[ocl_pkg::CODE_RIGHT] ? ONE : -ONE;
		end
	end

	// setup: along-edge delta, distance to edge, span across edge
	logic signed [MW-1:0] dx, dy, d_along, d_edge, d_span;
	logic [MW-1:0]        mag_along, mag_edge, mag_span;

	always_comb begin
		dx      = {x1_q[CW-1], x1_q} - {x0_q[CW-1], x0_q};
		dy      = {y1_q[CW-1], y1_q} - {y0_q[CW-1], y0_q};
		d_along = sel_y_q ? dx : dy;
		d_span  = sel_y_q ? dy : dx;
		d_edge  = {edge_q[CW-1], edge_q}
			- (sel_y_q ? {y0_q[CW-1], y0_q} : {x0_q[CW-1], x0_q});
		mag_along = d_along[MW-1] ? MW'(-d_along) : MW'(d_along);
		mag_edge  = d_edge[MW-1] ? MW'(-d_edge) : MW'(d_edge);
		mag_span  = d_span[MW-1] ? MW'(-d_span) : MW'(d_span);
	end

	// shared add/subtract unit
	logic [AW-1:0] op_a, op_b, sum;
	logic          op_sub;
	logic signed [CW-1:0] base;

	always_comb begin
		base   = sel_y_q ? x0_q : y0_q;
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_MUL: begin
				op_a = {1'b0, acc_q};
				op_b = {1'b0, ma_q};
			end
			ST_DIV: begin
				op_a   = AW'(acc_q[PW-1:MW-1]);
				op_b   = AW'(dvs_q);
				op_sub = 1'b1;
			end
			ST_UPD: begin
				op_a   = AW'(base);
				op_b   = AW'(acc_q[MW-1:0]);
				op_sub = neg_q;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
		sum = op_a + (op_b ^ {AW{op_sub}}) + AW'(op_sub);
	end

	logic          div_ge;
	logic [MW-1:0] div_rem;

	assign div_ge  = ~sum[AW-1];
	assign div_rem = div_ge ? sum[MW-1:0] : acc_q[PW-2:MW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_q     <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						x0_q    <= start_x;
						y0_q    <= start_y;
						x1_q    <= end_x;
						y1_q    <= end_y;
						pass_q  <= '0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (pass_q == PASS_W'(PASS_LIMIT) || (c0 & c1) != '0) begin
						done_q     <= 1'b1;
						accepted_q <= 1'b0;
						csx_q      <= '0;
						csy_q      <= '0;
						cex_q      <= '0;
						cey_q      <= '0;
						state_q    <= ST_IDLE;
					end else if ((c0 | c1) == '0) begin
						done_q     <= 1'b1;
						accepted_q <= 1'b1;
						csx_q      <= x0_q[OW-1:0];
						csy_q      <= y0_q[OW-1:0];
						cex_q      <= x1_q[OW-1:0];
						cey_q      <= y1_q[OW-1:0];
						state_q    <= ST_IDLE;
					end else begin
						sel_y_q <= sel_y_d;
						edge_q  <= edge_d;
						mv1_q   <= (c0 == '0);
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (d_span == '0) begin
						// no span across the edge: drop the segment
						done_q     <= 1'b1;
						accepted_q <= 1'b0;
						csx_q      <= '0;
						csy_q      <= '0;
						cex_q      <= '0;
						cey_q      <= '0;
						state_q    <= ST_IDLE;
					end else begin
						neg_q   <= d_along[MW-1] ^ d_edge[MW-1] ^ d_span[MW-1];
						ma_q    <= PW'(mag_along);
						mb_q    <= mag_edge;
						dvs_q   <= mag_span;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mb_q[0])
						acc_q <= sum[PW-1:0];
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
					if (cnt_q == CNT_W'(MW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					// remainder rides in the upper half, quotient shifts in below
					acc_q <= {div_rem, acc_q[MW-2:0], div_ge};
					if (cnt_q == CNT_W'(MW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_UPD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UPD: begin
					if (mv1_q) begin
						x1_q <= sel_y_q ? sum[CW-1:0] : edge_q;
						y1_q <= sel_y_q ? edge_q : sum[CW-1:0];
					end else begin
						x0_q <= sel_y_q ? sum[CW-1:0] : edge_q;
						y0_q <= sel_y_q ? edge_q : sum[CW-1:0];
					end
					pass_q  <= pass_q + 1'b1;
					state_q <= ST_TEST;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign accepted     = accepted_q;
	assign clip_start_x = csx_q;
	assign clip_start_y = csy_q;
	assign clip_end_x   = cex_q;
	assign clip_end_y   = cey_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer is still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not start the sequencer");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> (clip_start_x == '0 && clip_start_y == '0 &&
			clip_end_x == '0 && clip_end_y == '0))
		else $error("rejected segment with nonzero coordinates");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (pass_q <= PASS_W'(PASS_LIMIT)))
		else $error("pass counter beyond the pass limit");
`endif

endmodule
`default_nettype wire
